// ===== rtl/lea192_pkg.sv =====
// Shared types, constants and a helper function for the LEA-192 encryption pipeline.
// No dependencies; used by lea192_block_encrypt.
package lea192_pkg;

    // Block and key geometry
    localparam int WORD_W      = 32;
    localparam int DATA_WORDS  = 4;
    localparam int KEY_WORDS   = 6;
    localparam int ROUNDS_DFLT = 28;
    localparam int ADDR_W      = 5;

    // Key schedule constants
    localparam logic [WORD_W-1:0] DELTA [KEY_WORDS] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a,
        32'h78df30ec, 32'h715ea49e, 32'hc785da0a
    };

    localparam logic [4:0] SCHED_ROT [KEY_WORDS] = '{
        5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17
    };

    // One pipeline stage: data words and running key schedule
    typedef struct packed {
        logic [DATA_WORDS-1:0][WORD_W-1:0] x;
        logic [KEY_WORDS-1:0][WORD_W-1:0]  t;
    } stage_t;

    // Rotate left by an amount taken mod 32
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] s);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} << s;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

// ===== rtl/lea192_block_encrypt.sv =====
// LEA-192 block encryption as a fully unrolled round pipeline with APB key registers.
// Depends on lea192_pkg for constants, the stage type and the rotate helper.
//
// Usage:
//   Write the six key words over the APB port (word i at byte address 4*i)
//   while the pipeline is empty. Reads return the stored key words.
//   A plaintext block transfers when plain_valid is high and plain_stall low.
//   The ciphertext transfers when cipher_valid is high and cipher_stall low.
// Pipeline structure and throughput:
//   One register stage per round: a block taken into the first stage passes
//   through every round stage in order and shows on the ciphertext port from
//   the last one. One block enters per cycle while plain_stall is low;
//   the clock period is set by the per-round stage, one key schedule
//   add and one data add deep.
// Reset:
//   rst_n clears all key words to zero and empties the pipeline.
// Stall:
//   While cipher_stall holds, the output stage keeps its block. Empty stages
//   in front still fill, so plain_stall rises only once every stage ahead
//   of the input holds a block.
module lea192_block_encrypt #(
    parameter int ROUNDS = lea192_pkg::ROUNDS_DFLT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lea192_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Plaintext channel
    input  logic                              plain_valid,
    output logic                              plain_stall,
    input  logic [lea192_pkg::WORD_W-1:0]     plain_word0,
    input  logic [lea192_pkg::WORD_W-1:0]     plain_word1,
    input  logic [lea192_pkg::WORD_W-1:0]     plain_word2,
    input  logic [lea192_pkg::WORD_W-1:0]     plain_word3,
    // Ciphertext channel
    output logic                              cipher_valid,
    input  logic                              cipher_stall,
    output logic [lea192_pkg::WORD_W-1:0]     cipher_word0,
    output logic [lea192_pkg::WORD_W-1:0]     cipher_word1,
    output logic [lea192_pkg::WORD_W-1:0]     cipher_word2,
    output logic [lea192_pkg::WORD_W-1:0]     cipher_word3
);

    localparam int W = lea192_pkg::WORD_W;
    localparam int K = lea192_pkg::KEY_WORDS;

    // Key registers
    logic [W-1:0] key_reg  [K];
    logic [W-1:0] key_next [K];
    logic [2:0]   cfg_index;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            key_next[i] = key_reg[i];
        end
        if (cfg_write && (cfg_index < 3'(K)))
        begin
            key_next[cfg_index] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < K; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < K; i++)
            begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    // Return the addressed key word, zero beyond the list
    always_comb
    begin
        if (cfg_index < 3'(K))
        begin
            prdata = key_reg[cfg_index];
        end
        else
        begin
            prdata = '0;
        end
    end

    // Round pipeline
    lea192_pkg::stage_t stage_reg [ROUNDS];
    lea192_pkg::stage_t round_in  [ROUNDS];
    lea192_pkg::stage_t round_out [ROUNDS];
    logic [ROUNDS-1:0]  valid_reg;
    logic [ROUNDS-1:0]  valid_next;
    logic [ROUNDS-1:0]  stage_ready;
    logic [ROUNDS-1:0]  prev_valid;

    // Load the first stage from the input words and the key
    always_comb
    begin
        round_in[0].x[0] = plain_word0;
        round_in[0].x[1] = plain_word1;
        round_in[0].x[2] = plain_word2;
        round_in[0].x[3] = plain_word3;
        for (int i = 0; i < K; i++)
        begin
            round_in[0].t[i] = key_reg[i];
        end
    end

    assign prev_valid[0] = plain_valid;

    genvar gi, gj;
    generate
        for (gi = 0; gi < ROUNDS; gi++)
        begin : g_round
            localparam int R  = gi;
            localparam int DI = R % 6;
            logic [K-1:0][W-1:0] t_new;
            logic [W-1:0] sum0, sum1, sum2;

            if (gi > 0)
            begin : g_link
                assign round_in[gi]   = stage_reg[gi-1];
                assign prev_valid[gi] = valid_reg[gi-1];
            end

            // Advance the key schedule by one round
            for (gj = 0; gj < K; gj++)
            begin : g_sched
                localparam int J = gj;
                localparam logic [W-1:0] DROT =
                    lea192_pkg::rotl32(lea192_pkg::DELTA[DI], 5'((R + J) % 32));
                assign t_new[gj] = lea192_pkg::rotl32(round_in[gi].t[gj] + DROT,
                                                      lea192_pkg::SCHED_ROT[gj]);
            end

            // Mix the data words and shift word 0 into word 3
            assign sum0 = (round_in[gi].x[0] ^ t_new[0]) + (round_in[gi].x[1] ^ t_new[1]);
            assign sum1 = (round_in[gi].x[1] ^ t_new[2]) + (round_in[gi].x[2] ^ t_new[3]);
            assign sum2 = (round_in[gi].x[2] ^ t_new[4]) + (round_in[gi].x[3] ^ t_new[5]);

            always_comb
            begin
                round_out[gi].t    = t_new;
                round_out[gi].x[0] = {sum0[22:0], sum0[31:23]};
                round_out[gi].x[1] = {sum1[4:0], sum1[31:5]};
                round_out[gi].x[2] = {sum2[2:0], sum2[31:3]};
                round_out[gi].x[3] = round_in[gi].x[0];
            end

            // A stage takes new data when empty or when its own block moves on
            if (gi == ROUNDS - 1)
            begin : g_last
                assign stage_ready[gi] = !valid_reg[gi] || !cipher_stall;
            end
            else
            begin : g_mid
                assign stage_ready[gi] = !valid_reg[gi] || stage_ready[gi+1];
            end

            assign valid_next[gi] = stage_ready[gi] ? prev_valid[gi] : valid_reg[gi];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[gi] <= 1'b0;
                end
                else
                begin
                    valid_reg[gi] <= valid_next[gi];
                end
            end

            // Hold payload unless the stage advances with a valid block
            always_ff @(posedge clk)
            begin
                if (stage_ready[gi] && prev_valid[gi])
                begin
                    stage_reg[gi] <= round_out[gi];
                end
            end
        end
    endgenerate

    // Drive the channels
    assign plain_stall  = !stage_ready[0];
    assign cipher_valid = valid_reg[ROUNDS-1];
    assign cipher_word0 = stage_reg[ROUNDS-1].x[0];
    assign cipher_word1 = stage_reg[ROUNDS-1].x[1];
    assign cipher_word2 = stage_reg[ROUNDS-1].x[2];
    assign cipher_word3 = stage_reg[ROUNDS-1].x[3];

endmodule

// ===== tb/tb_lea192_block_encrypt.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lea192_block_encrypt: drives plaintext blocks and APB key writes,
// predicts each ciphertext with an in-bench LEA-192 round model and checks it in order.
// Depends on lea192_pkg and the block RTL only.
module tb_lea192_block_encrypt;

    localparam int W             = lea192_pkg::WORD_W;
    localparam int NKEY          = lea192_pkg::KEY_WORDS;
    localparam int NWORD         = lea192_pkg::DATA_WORDS;
    localparam int AW            = lea192_pkg::ADDR_W;
    localparam int NROUND        = lea192_pkg::ROUNDS_DFLT;
    // Register map: key words first, then unmapped slots up to the top of paddr
    localparam int REG_KEY0      = 0;
    localparam int REG_SPARE_LO  = NKEY;
    localparam int REG_SPARE_HI  = (1 << AW) / 4 - 1;
    localparam int IDLE_PCT      = 33;
    localparam int ERR_PRINT_MAX = 40;
    localparam int DRAIN_CYCLES  = NROUND + 8;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_BLOCKS  = 300;
    localparam int PAUSE_BLOCKS  = 50;
    localparam longint TIMEOUT_NS = 2_000_000;

    typedef logic [W-1:0]             word_t;
    typedef logic [NWORD-1:0][W-1:0]  block_t;
    typedef logic [NKEY-1:0][W-1:0]   key_t;

    // Key schedule constants, highest index leftmost
    localparam logic [NKEY-1:0][W-1:0] SCHED_DELTA = {
        32'hc785da0a, 32'h715ea49e, 32'h78df30ec,
        32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
    };
    localparam logic [NKEY-1:0][4:0] KEY_ROT = {5'd17, 5'd13, 5'd11, 5'd6, 5'd3, 5'd1};

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [AW-1:0] paddr      = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        plain_valid  = 1'b0;
    logic        plain_stall;
    word_t       plain_word0  = '0;
    word_t       plain_word1  = '0;
    word_t       plain_word2  = '0;
    word_t       plain_word3  = '0;
    logic        cipher_valid;
    logic        cipher_stall = 1'b0;
    word_t       cipher_word0;
    word_t       cipher_word1;
    word_t       cipher_word2;
    word_t       cipher_word3;

    bit          idle_en  = 1'b1;
    bit          stall_en = 1'b1;
    key_t        key_model = '0;
    block_t      cipher_expected_q [$];
    int          err_cnt   = 0;
    int          n_sent    = 0;
    int          n_checked = 0;
    int          n_writes  = 0;
    int          n_reads   = 0;
    int          n_keys    = 0;

    lea192_block_encrypt u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .plain_valid  (plain_valid),
        .plain_stall  (plain_stall),
        .plain_word0  (plain_word0),
        .plain_word1  (plain_word1),
        .plain_word2  (plain_word2),
        .plain_word3  (plain_word3),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_word0 (cipher_word0),
        .cipher_word1 (cipher_word1),
        .cipher_word2 (cipher_word2),
        .cipher_word3 (cipher_word3)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Rotate left; the amount wraps at the word size, so 32 is a no-op
    function automatic word_t rol(word_t v, int s);
        int k;
        k = s & (W - 1);
        return (k == 0) ? v : ((v << k) | (v >> (W - k)));
    endfunction

    // Full LEA-192 encryption of one block; the schedule restarts from the key each time
    function automatic block_t lea_encrypt_block(block_t plain, key_t key);
        key_t   t;
        block_t x;
        word_t  d;
        word_t  n0;
        word_t  n1;
        word_t  n2;
        t = key;
        x = plain;
        for (int r = 0; r < NROUND; r++)
        begin
            d = SCHED_DELTA[r % NKEY];
            for (int j = 0; j < NKEY; j++)
                t[j] = rol(t[j] + rol(d, r + j), KEY_ROT[j]);
            // right rotations by 5 and 3 written as left rotations
            n0 = rol((x[0] ^ t[0]) + (x[1] ^ t[1]), 9);
            n1 = rol((x[1] ^ t[2]) + (x[2] ^ t[3]), W - 5);
            n2 = rol((x[2] ^ t[4]) + (x[3] ^ t[5]), W - 3);
            x[3] = x[0];
            x[0] = n0;
            x[1] = n1;
            x[2] = n2;
        end
        return x;
    endfunction

    // Bias toward all-zero, all-one and single-bit words
    function automatic word_t rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(W - 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic block_t rand_block();
        block_t b;
        for (int i = 0; i < NWORD; i++)
            b[i] = rand_word();
        return b;
    endfunction

    function automatic key_t rand_key();
        key_t k;
        for (int i = 0; i < NKEY; i++)
            k[i] = rand_word();
        return k;
    endfunction

    // Receiver: stall at random on the falling edge
    always @(negedge clk)
    begin
        cipher_stall <= stall_en && ($urandom_range(99) < IDLE_PCT);
    end

    // Check every ciphertext transfer against the oldest prediction
    always @(posedge clk)
    begin : check_cipher
        block_t got;
        block_t want;
        if (rst_n && cipher_valid && !cipher_stall)
        begin
            got = {cipher_word3, cipher_word2, cipher_word1, cipher_word0};
            if (cipher_expected_q.size() == 0)
            begin
                if (err_cnt < ERR_PRINT_MAX)
                    $display("%0t ns: unexpected ciphertext, expected none, got %h", $time, got);
                err_cnt++;
            end
            else
            begin
                want = cipher_expected_q.pop_front();
                for (int f = 0; f < NWORD; f++)
                begin
                    if (got[f] !== want[f])
                    begin
                        if (err_cnt < ERR_PRINT_MAX)
                            $display("%0t ns: cipher_word%0d mismatch, expected %h, got %h",
                                     $time, f, want[f], got[f]);
                        err_cnt++;
                    end
                end
            end
            n_checked++;
        end
    end

    // Offer one plaintext block, with random gaps ahead of it, and predict it on transfer
    task automatic send_block(input block_t blk);
        @(negedge clk);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            plain_valid <= 1'b0;
            @(negedge clk);
        end
        plain_valid <= 1'b1;
        {plain_word3, plain_word2, plain_word1, plain_word0} <= blk;
        @(posedge clk);
        while (plain_stall)
            @(posedge clk);
        cipher_expected_q.push_back(lea_encrypt_block(blk, key_model));
        n_sent++;
    endtask

    task automatic random_burst(input int count);
        repeat (count)
            send_block(rand_block());
    endtask

    // Drop valid and hold until every predicted block has come out
    task automatic wait_cipher_drain();
        @(negedge clk);
        plain_valid <= 1'b0;
        while (cipher_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input int idx, input word_t val);
        logic [AW-1:0] addr;
        addr = AW'(idx * 4);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx < NKEY)
            key_model[idx] = val;
        n_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input int idx, output word_t val);
        logic [AW-1:0] addr;
        addr = AW'(idx * 4);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        val = prdata;
        n_reads++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_key_readback();
        word_t got;
        for (int i = 0; i < NKEY; i++)
        begin
            apb_read(REG_KEY0 + i, got);
            if (got !== key_model[i])
            begin
                if (err_cnt < ERR_PRINT_MAX)
                    $display("%0t ns: key_word%0d readback mismatch, expected %h, got %h",
                             $time, i, key_model[i], got);
                err_cnt++;
            end
        end
    endtask

    // Load all six key words, then read them back; call only with the pipeline empty
    task automatic set_key(input key_t k);
        for (int i = 0; i < NKEY; i++)
            apb_write(REG_KEY0 + i, k[i]);
        n_keys++;
        check_key_readback();
    endtask

    // Reset key of zero: pattern and single-word extremes of the plaintext
    task automatic test_reset_key_blocks();
        block_t blk;
        check_key_readback();
        send_block('0);
        send_block('1);
        send_block({NWORD{32'h55555555}});
        send_block({NWORD{32'haaaaaaaa}});
        send_block({32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff});
        send_block({NWORD{32'h80000001}});
        for (int i = 0; i < NWORD; i++)
        begin
            blk    = '0;
            blk[i] = '1;
            send_block(blk);
        end
        wait_cipher_drain();
    endtask

    // All-one and alternating keys at the block extremes
    task automatic test_key_extremes();
        set_key('1);
        send_block('0);
        send_block('1);
        wait_cipher_drain();
        set_key({32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                 32'h55555555, 32'haaaaaaaa, 32'h55555555});
        send_block('0);
        send_block('1);
        wait_cipher_drain();
    endtask

    // Writes to the slots above the key words must leave the key alone
    task automatic test_unmapped_writes();
        set_key(rand_key());
        for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
            apb_write(i, $urandom);
        check_key_readback();
        send_block(rand_block());
        send_block('1);
        send_block('0);
        wait_cipher_drain();
    endtask

    // Random keys with random gaps on both channels
    task automatic test_random_keys();
        repeat (RANDOM_PHASES)
        begin
            set_key(rand_key());
            random_burst(PHASE_BLOCKS);
            wait_cipher_drain();
        end
    endtask

    // Long stretch at full rate on both sides
    task automatic test_back_to_back();
        idle_en  = 1'b0;
        stall_en = 1'b0;
        set_key(rand_key());
        random_burst(PHASE_BLOCKS);
        wait_cipher_drain();
        idle_en  = 1'b1;
        stall_en = 1'b1;
    endtask

    // Sender holds off mid-stream until the pipeline is empty, then resumes
    task automatic test_pause_and_drain();
        set_key(rand_key());
        random_burst(PAUSE_BLOCKS);
        wait_cipher_drain();
        random_burst(PAUSE_BLOCKS);
        wait_cipher_drain();
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_key_blocks();
        test_key_extremes();
        test_unmapped_writes();
        test_random_keys();
        test_back_to_back();
        test_pause_and_drain();

        wait_cipher_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Encrypted %0d blocks, checked %0d, under %0d keys (zero, all-one, alternating,",
                 n_sent, n_checked, n_keys + 1);
        $display("random); %0d register writes incl. unmapped slots, %0d read-backs, %0d errors",
                 n_writes, n_reads, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hang guard
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d blocks still expected", cipher_expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
